// ----- rtl/s2u_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package s2u_pkg;

   // Default sizes of the value and of the position counter.
   localparam int VALUE_BITS_DEFAULT    = 64;
   localparam int POSITION_BITS_DEFAULT = 12;

   localparam int CHAR_BITS = 8;
   localparam int BASE_BITS = 6;

   // Radix codes with a meaning of their own.
   localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_MIN     = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCTAL   = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DECIMAL = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX     = 6'd36;

   // Digit code for a byte that is no digit in any radix.
   localparam logic [BASE_BITS-1:0] NO_DIGIT = 6'd63;
   localparam logic [CHAR_BITS-1:0] LETTER_OFFSET = 8'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;

   // Status of one digit step.
   typedef struct packed {
      logic digit_ok;   // radix valid and digit below it
      logic overflow;   // accumulator * radix + digit does not fit
   } mac_status_type;

   // Digit value of a byte in radix 36, or NO_DIGIT.
   function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] diff;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         diff = c - CHAR_UPPER_A + LETTER_OFFSET;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         diff = c - CHAR_LOWER_A + LETTER_OFFSET;
      end else begin
         diff = CHAR_BITS'(NO_DIGIT);
      end
      return diff[BASE_BITS-1:0];
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/s2u_digit_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One digit step: decodes the byte, checks it against the radix and forms
// accumulator * radix + digit at full width so that overflow is seen directly.
module s2u_digit_mac #(
   parameter int VALUE_BITS = s2u_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic [VALUE_BITS-1:0]          acc_value,
   input  wire logic [s2u_pkg::BASE_BITS-1:0]  digit_base,
   input  wire logic [s2u_pkg::CHAR_BITS-1:0]  char_byte,
   output logic      [VALUE_BITS-1:0]          acc_next,
   output s2u_pkg::mac_status_type             status
);

   localparam int WIDE_BITS = VALUE_BITS + s2u_pkg::BASE_BITS;

   logic [s2u_pkg::BASE_BITS-1:0] digit;
   logic                          base_ok;
   logic [WIDE_BITS-1:0]          product;

   always_comb begin
      digit   = s2u_pkg::digit_of(char_byte);
      base_ok = (digit_base >= s2u_pkg::BASE_MIN) && (digit_base <= s2u_pkg::BASE_MAX);
      product = ({{s2u_pkg::BASE_BITS{1'b0}}, acc_value} * WIDE_BITS'(digit_base))
              + WIDE_BITS'(digit);
      acc_next        = product[VALUE_BITS-1:0];
      status.digit_ok = base_ok && (digit < digit_base);
      status.overflow = |product[WIDE_BITS-1:VALUE_BITS];
   end

endmodule

`default_nettype wire

// ----- rtl/string_to_unsigned_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Result path: a string's last character passes the input register, then the result register,
//   which raises rsp_tvalid and holds the result until it is taken.
// Throughput: one character per cycle, set by the single digit step (one multiply-add
//   by the radix plus the overflow check) between the input and the state registers. A
//   string's last character waits only while the previous result is still held on rsp.
// Reset (synchronous, active high) clears the parse state, the radix register and the valid
//   bits of both channel registers; no clearing pass, beats are taken once reset is released.
module string_to_unsigned_parser #(
   parameter  int VALUE_BITS    = s2u_pkg::VALUE_BITS_DEFAULT,
   parameter  int POSITION_BITS = s2u_pkg::POSITION_BITS_DEFAULT,
   localparam int RSP_DATA_BITS = ((VALUE_BITS + POSITION_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   // Radix register write channel.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [s2u_pkg::BASE_BITS-1:0]     csr_wdata,   // number_base

   // Character stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [s2u_pkg::CHAR_BITS-1:0]     req_tdata,   // char_byte
   input  wire logic                              req_tlast,   // last_char

   // Result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]          rsp_tdata,   // parsed_value, end_position, zero pad
   output logic      [1:0]                        rsp_tuser    // overflow_flag, converted_flag
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // The phases of one string, in the order they are normally passed.
   typedef enum logic [2:0] {
      PH_SPACE,    // skipping leading white space
      PH_SIGN,     // sign taken, first digit expected
      PH_ZERO,     // a leading zero in automatic or hex radix
      PH_ZERO_X,   // zero then x, waiting for a hex digit
      PH_DIGITS,   // reading digits
      PH_DONE      // conversion stopped, rest of the string ignored
   } phase_type;

   // Input register.
   logic                           in_valid_ff;
   logic [s2u_pkg::CHAR_BITS-1:0]  in_char_ff;
   logic                           in_last_ff;

   // Radix register.
   logic [s2u_pkg::BASE_BITS-1:0]  number_base_ff;

   // Parse state and its next values.
   phase_type                      phase_ff,      phase_in;
   logic [VALUE_BITS-1:0]          acc_ff,        acc_in;
   logic                           negative_ff,   negative_in;
   logic                           overflow_ff,   overflow_in;
   logic                           seen_ff,       seen_in;
   logic [s2u_pkg::BASE_BITS-1:0]  active_base_ff, active_base_in;
   logic [POSITION_BITS-1:0]       index_ff,      index_in;
   logic [POSITION_BITS-1:0]       stop_ff,       stop_in;

   // Result register.
   logic                           rsp_valid_ff;
   logic [VALUE_BITS-1:0]          rsp_value_ff,    rsp_value_in;
   logic                           rsp_overflow_ff, rsp_overflow_in;
   logic                           rsp_conv_ff,     rsp_conv_in;
   logic [POSITION_BITS-1:0]       rsp_end_ff,      rsp_end_in;

   logic                           advance;
   logic                           in_accept;
   logic                           take_first;
   logic                           take_digit;
   logic [s2u_pkg::BASE_BITS-1:0]  base_start;
   logic [s2u_pkg::BASE_BITS-1:0]  base_first;
   logic [s2u_pkg::BASE_BITS-1:0]  mac_base;
   logic [VALUE_BITS-1:0]          mac_acc;
   s2u_pkg::mac_status_type        mac_status;
   logic [POSITION_BITS-1:0]       index_next;

   // The registered character moves on at once unless it ends a string and the
   // previous result still waits to be taken; only then does the input side stall.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_accept  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_end_ff, rsp_value_ff});
   assign rsp_tuser  = {rsp_conv_ff, rsp_overflow_ff};

   assign index_next = (index_ff == POS_MAX) ? index_ff : index_ff + 1'b1;

   // The radix is sampled on the first character of each string; later writes
   // wait for the next string.
   always_comb begin
      base_start = (index_ff == '0) ? number_base_ff : active_base_ff;
      base_first = (base_start == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_DECIMAL : base_start;
      case (phase_ff)
         PH_SPACE, PH_SIGN: begin
            mac_base = base_first;
         end
         PH_ZERO: begin
            mac_base = (active_base_ff == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_OCTAL
                                                              : active_base_ff;
         end
         PH_ZERO_X: begin
            mac_base = s2u_pkg::BASE_HEX;
         end
         default: begin
            mac_base = active_base_ff;
         end
      endcase
   end

   s2u_digit_mac #(
      .VALUE_BITS (VALUE_BITS)
   ) u_digit_mac (
      .acc_value  (acc_ff),
      .digit_base (mac_base),
      .char_byte  (in_char_ff),
      .acc_next   (mac_acc),
      .status     (mac_status)
   );

   // Next parse state for the registered character.
   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      negative_in    = negative_ff;
      overflow_in    = overflow_ff;
      seen_in        = seen_ff;
      active_base_in = base_start;
      stop_in        = stop_ff;
      index_in       = index_next;
      take_first     = 1'b0;
      take_digit     = 1'b0;

      case (phase_ff)
         PH_SPACE: begin
            if (s2u_pkg::is_space(in_char_ff)) begin
               phase_in = PH_SPACE;
            end else if (in_char_ff == s2u_pkg::CHAR_MINUS) begin
               negative_in = 1'b1;
               phase_in    = PH_SIGN;
            end else if (in_char_ff == s2u_pkg::CHAR_PLUS) begin
               phase_in = PH_SIGN;
            end else begin
               take_first = 1'b1;
            end
         end
         PH_SIGN: begin
            take_first = 1'b1;
         end
         PH_ZERO: begin
            if (in_char_ff == s2u_pkg::CHAR_LOWER_X || in_char_ff == s2u_pkg::CHAR_UPPER_X) begin
               phase_in = PH_ZERO_X;
            end else begin
               active_base_in = mac_base;
               phase_in       = PH_DIGITS;
               take_digit     = 1'b1;
            end
         end
         PH_ZERO_X: begin
            // The prefix counts only when a hex digit follows it.
            if (s2u_pkg::digit_of(in_char_ff) < s2u_pkg::BASE_HEX) begin
               active_base_in = s2u_pkg::BASE_HEX;
               phase_in       = PH_DIGITS;
               take_digit     = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DIGITS: begin
            take_digit = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (take_first) begin
         if ((base_start == s2u_pkg::BASE_AUTO || base_start == s2u_pkg::BASE_HEX)
             && in_char_ff == s2u_pkg::CHAR_ZERO) begin
            // A leading zero is a digit already, whatever follows it.
            phase_in = PH_ZERO;
            seen_in  = 1'b1;
            stop_in  = index_next;
         end else begin
            // An invalid radix fails the digit check below and stops the parse.
            active_base_in = base_first;
            phase_in       = PH_DIGITS;
            take_digit     = 1'b1;
         end
      end

      if (take_digit) begin
         if (!mac_status.digit_ok) begin
            phase_in = PH_DONE;
         end else begin
            // Once overflow is seen the accumulator is frozen and further digits
            // only move the end position.
            if (overflow_ff || mac_status.overflow) begin
               overflow_in = 1'b1;
            end else begin
               acc_in = mac_acc;
            end
            seen_in = 1'b1;
            stop_in = index_next;
         end
      end
   end

   // Result for a string that ends with the registered character.
   always_comb begin
      if (overflow_in) begin
         rsp_value_in    = {VALUE_BITS{1'b1}};
         rsp_overflow_in = 1'b1;
         rsp_conv_in     = 1'b1;
         rsp_end_in      = stop_in;
      end else if (seen_in) begin
         rsp_value_in    = negative_in ? (VALUE_BITS'(0) - acc_in) : acc_in;
         rsp_overflow_in = 1'b0;
         rsp_conv_in     = 1'b1;
         rsp_end_in      = stop_in;
      end else begin
         rsp_value_in    = '0;
         rsp_overflow_in = 1'b0;
         rsp_conv_in     = 1'b0;
         rsp_end_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         number_base_ff <= s2u_pkg::BASE_AUTO;
         phase_ff       <= PH_SPACE;
         acc_ff         <= '0;
         negative_ff    <= 1'b0;
         overflow_ff    <= 1'b0;
         seen_ff        <= 1'b0;
         active_base_ff <= s2u_pkg::BASE_AUTO;
         index_ff       <= '0;
         stop_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            number_base_ff <= csr_wdata;
         end

         if (in_accept) begin
            in_valid_ff <= 1'b1;
            in_char_ff  <= req_tdata;
            in_last_ff  <= req_tlast;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            if (in_last_ff) begin
               // Deliver the result and start the next string from scratch.
               rsp_valid_ff    <= 1'b1;
               rsp_value_ff    <= rsp_value_in;
               rsp_overflow_ff <= rsp_overflow_in;
               rsp_conv_ff     <= rsp_conv_in;
               rsp_end_ff      <= rsp_end_in;
               phase_ff        <= PH_SPACE;
               acc_ff          <= '0;
               negative_ff     <= 1'b0;
               overflow_ff     <= 1'b0;
               seen_ff         <= 1'b0;
               active_base_ff  <= s2u_pkg::BASE_AUTO;
               index_ff        <= '0;
               stop_ff         <= '0;
            end else begin
               phase_ff        <= phase_in;
               acc_ff          <= acc_in;
               negative_ff     <= negative_in;
               overflow_ff     <= overflow_in;
               seen_ff         <= seen_in;
               active_base_ff  <= active_base_in;
               index_ff        <= index_in;
               stop_ff         <= stop_in;
            end
         end
      end
   end

endmodule

`default_nettype wire
